FILE: sv/ifp_pkg.sv
// Shared types and constants for the integer format-string printer.
// Holds the channel payload structs, the command passed from front to back,
// the character codes and the hex digit table. No dependencies.
package ifp_pkg;

  localparam int unsigned NumDigits = 20;
  localparam int unsigned DigitBits = 4 * NumDigits;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChLong    = 8'h6c;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChHex     = 8'h78;

  localparam logic [7:0] HexChars [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef struct packed {
    logic [7:0]  fmt_byte;
    logic [63:0] arg_value;
    logic        is_last;
  } ifp_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
  } ifp_out_t;

  // One unit of work for the back end: an echoed byte or a conversion.
  typedef struct packed {
    logic        is_conv;
    logic        hex;
    logic        prefix;
    logic        zero_pad;
    logic [5:0]  pad_width;
    logic [7:0]  echo_char;
    logic [63:0] value;
  } ifp_cmd_t;

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return HexChars[nib];
  endfunction

endpackage

FILE: sv/ifp_front.sv
// Front end: parses format bytes, keeps the spec state, issues commands.
// Depends on ifp_pkg.
module ifp_front #(
  parameter int unsigned MaxWidth = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  ifp_pkg::ifp_in_t in_data_i,
  output logic             push_o,
  output ifp_pkg::ifp_cmd_t cmd_o
);

  logic       spec_open_q, spec_open_d;
  logic       prefix_q, prefix_d;
  logic       zpad_q, zpad_d;
  logic       long_q, long_d;
  logic       coll_q, coll_d;
  logic [5:0] pad_q, pad_d;

  logic [7:0]  c;
  logic        is_digit;
  logic        handled;
  logic        emit_conv;
  logic        emit_hex;
  logic [9:0]  wide_w;
  logic [63:0] val;

  always_comb begin
    c        = in_data_i.fmt_byte;
    is_digit = (c >= ifp_pkg::ChZero) && (c <= ifp_pkg::ChNine);
    wide_w   = {4'b0, pad_q} * 10'd10 + {6'b0, c[3:0]};

    spec_open_d = spec_open_q;
    prefix_d    = prefix_q;
    zpad_d      = zpad_q;
    long_d      = long_q;
    coll_d      = coll_q;
    pad_d       = pad_q;
    handled     = 1'b0;
    emit_conv   = 1'b0;
    emit_hex    = 1'b0;
    push_o      = 1'b0;

    if (!spec_open_q) begin
      if (c == ifp_pkg::ChPercent) begin
        spec_open_d = 1'b1;
        prefix_d    = 1'b0;
        zpad_d      = 1'b0;
        long_d      = 1'b0;
        coll_d      = 1'b0;
        pad_d       = '0;
      end else begin
        push_o = accept_i;
      end
    end else begin
      if (coll_q) begin
        if (is_digit) begin
          pad_d   = (wide_w > 10'(MaxWidth)) ? 6'(MaxWidth) : wide_w[5:0];
          handled = 1'b1;
        end else begin
          coll_d = 1'b0;
        end
      end
      if (!handled) begin
        unique case (c)
          ifp_pkg::ChHash: prefix_d = 1'b1;
          ifp_pkg::ChLong: long_d   = 1'b1;
          ifp_pkg::ChZero: begin
            zpad_d = 1'b1;
            coll_d = 1'b1;
            pad_d  = '0;
          end
          ifp_pkg::ChMinus, ifp_pkg::ChSpace, ifp_pkg::ChPlus: ;
          ifp_pkg::ChHex: begin
            emit_conv   = 1'b1;
            emit_hex    = 1'b1;
            spec_open_d = 1'b0;
          end
          default: begin
            emit_conv   = 1'b1;
            spec_open_d = 1'b0;
          end
        endcase
      end
    end

    // Flush a spec left open by the final byte as decimal.
    if (in_data_i.is_last && spec_open_d) begin
      emit_conv = 1'b1;
      emit_hex  = 1'b0;
    end

    val = long_d ? in_data_i.arg_value : {32'b0, in_data_i.arg_value[31:0]};

    cmd_o.is_conv   = emit_conv;
    cmd_o.hex       = emit_hex;
    cmd_o.prefix    = prefix_d;
    cmd_o.zero_pad  = zpad_d;
    cmd_o.pad_width = pad_d;
    cmd_o.echo_char = c;
    cmd_o.value     = val;
    if (emit_conv) begin
      push_o = accept_i;
    end

    if (in_data_i.is_last) begin
      spec_open_d = 1'b0;
      prefix_d    = 1'b0;
      zpad_d      = 1'b0;
      long_d      = 1'b0;
      coll_d      = 1'b0;
      pad_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spec_open_q <= 1'b0;
      prefix_q    <= 1'b0;
      zpad_q      <= 1'b0;
      long_q      <= 1'b0;
      coll_q      <= 1'b0;
      pad_q       <= '0;
    end else if (accept_i) begin
      spec_open_q <= spec_open_d;
      prefix_q    <= prefix_d;
      zpad_q      <= zpad_d;
      long_q      <= long_d;
      coll_q      <= coll_d;
      pad_q       <= pad_d;
    end
  end

endmodule

FILE: sv/ifp_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on ifp_pkg.
module ifp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ifp_pkg::ifp_cmd_t push_cmd_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output ifp_pkg::ifp_cmd_t head_o
);

  ifp_pkg::ifp_cmd_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: sv/ifp_back.sv
// Back end: echoes bytes; decimal to digits by shift-and-add-3, four bits a cycle;
// strips leading zeros, emits prefix, padding and digits. Depends on ifp_pkg.
module ifp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  ifp_pkg::ifp_cmd_t cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ifp_pkg::ifp_out_t out_data_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SConv   = 3'd1;
  localparam logic [2:0] SStrip  = 3'd2;
  localparam logic [2:0] SPre0   = 3'd3;
  localparam logic [2:0] SPreX   = 3'd4;
  localparam logic [2:0] SPad    = 3'd5;
  localparam logic [2:0] SDigits = 3'd6;

  localparam int unsigned DB = ifp_pkg::DigitBits;

  // Four dependent double-dabble steps over {bcd, bin}.
  function automatic logic [DB+63:0] dd_step4(logic [DB+63:0] acc);
    logic [DB+63:0] a;
    a = acc;
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < ifp_pkg::NumDigits; k++) begin
        if (a[64+4*k +: 4] >= 4'd5) begin
          a[64+4*k +: 4] = a[64+4*k +: 4] + 4'd3;
        end
      end
      a = {a[DB+62:0], 1'b0};
    end
    return a;
  endfunction

  logic [2:0]    state_q, state_d;
  logic [DB-1:0] digits_q, digits_d;
  logic [63:0]   bin_q, bin_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [4:0]    ndig_q, ndig_d;
  logic [5:0]    pad_cnt_q, pad_cnt_d;
  logic          prefix_q, prefix_d;
  logic          zpad_q, zpad_d;
  logic [5:0]    padw_q, padw_d;
  logic          out_valid_q, out_valid_d;
  ifp_pkg::ifp_out_t out_q, out_d;

  logic       out_ready;
  logic       emit;
  logic [7:0] ch;
  logic       run_end;
  logic [3:0] top_nib;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign top_nib     = digits_q[DB-1 -: 4];

  always_comb begin
    state_d   = state_q;
    digits_d  = digits_q;
    bin_d     = bin_q;
    cnt_d     = cnt_q;
    ndig_d    = ndig_q;
    pad_cnt_d = pad_cnt_q;
    prefix_d  = prefix_q;
    zpad_d    = zpad_q;
    padw_d    = padw_q;
    emit      = 1'b0;
    ch        = '0;
    run_end   = 1'b0;
    pop_o     = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (cmd_valid_i) begin
          if (!cmd_i.is_conv) begin
            if (out_ready) begin
              pop_o   = 1'b1;
              emit    = 1'b1;
              ch      = cmd_i.echo_char;
              run_end = 1'b1;
            end
          end else begin
            pop_o    = 1'b1;
            prefix_d = cmd_i.prefix;
            zpad_d   = cmd_i.zero_pad;
            padw_d   = cmd_i.pad_width;
            if (cmd_i.hex) begin
              digits_d = {{(DB-64){1'b0}}, cmd_i.value};
              ndig_d   = 5'(ifp_pkg::NumDigits);
              state_d  = SStrip;
            end else begin
              digits_d = '0;
              if (cmd_i.value[63:32] == 32'h0) begin
                bin_d = {cmd_i.value[31:0], 32'h0};
                cnt_d = 4'd7;
              end else begin
                bin_d = cmd_i.value;
                cnt_d = 4'd15;
              end
              state_d = SConv;
            end
          end
        end
      end
      SConv: begin
        {digits_d, bin_d} = dd_step4({digits_q, bin_q});
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          ndig_d  = 5'(ifp_pkg::NumDigits);
          state_d = SStrip;
        end
      end
      SStrip: begin
        if (top_nib == 4'h0 && ndig_q > 5'd1) begin
          digits_d = {digits_q[DB-5:0], 4'h0};
          ndig_d   = ndig_q - 5'd1;
        end else begin
          pad_cnt_d = (zpad_q && padw_q > {1'b0, ndig_q}) ?
                      padw_q - {1'b0, ndig_q} : 6'd0;
          state_d   = prefix_q ? SPre0 : SPad;
        end
      end
      SPre0: begin
        if (out_ready) begin
          emit    = 1'b1;
          ch      = ifp_pkg::ChZero;
          state_d = SPreX;
        end
      end
      SPreX: begin
        if (out_ready) begin
          emit    = 1'b1;
          ch      = ifp_pkg::ChHex;
          state_d = SPad;
        end
      end
      SPad: begin
        if (pad_cnt_q == 6'd0) begin
          state_d = SDigits;
        end else if (out_ready) begin
          emit      = 1'b1;
          ch        = ifp_pkg::ChZero;
          pad_cnt_d = pad_cnt_q - 6'd1;
        end
      end
      SDigits: begin
        if (out_ready) begin
          emit     = 1'b1;
          ch       = ifp_pkg::hex_char(top_nib);
          run_end  = (ndig_q == 5'd1);
          digits_d = {digits_q[DB-5:0], 4'h0};
          ndig_d   = ndig_q - 5'd1;
          if (ndig_q == 5'd1) begin
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready) begin
      out_valid_d      = emit;
      out_d.out_char   = ch;
      out_d.run_end    = run_end;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q  <= digits_d;
    bin_q     <= bin_d;
    cnt_q     <= cnt_d;
    ndig_q    <= ndig_d;
    pad_cnt_q <= pad_cnt_d;
    prefix_q  <= prefix_d;
    zpad_q    <= zpad_d;
    padw_q    <= padw_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/integer_format_string_printer_top.sv
// Top level: front parser, two-entry command queue, back-end emitter. Depends on ifp_pkg,
// ifp_front, ifp_queue, ifp_back. When the back end is free, an echo beat passes through
// the queue entry and the registered output beat; echoes stream at one per cycle while
// the output is not stalled. A conversion holds the back end through decimal conversion
// (shorter for values within 32 bits), strip, prefix, pad zeros, digits, output stalls.
// Reset (asynchronous, active low) clears the spec state, the queue and the output stage.
module integer_format_string_printer_top #(
  parameter int unsigned MaxWidth = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ifp_pkg::ifp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ifp_pkg::ifp_out_t out_data_o
);

  logic              accept;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_valid;
  ifp_pkg::ifp_cmd_t push_cmd;
  ifp_pkg::ifp_cmd_t head_cmd;

  // Hold the input whenever the queue cannot take another command.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Parse each beat and issue at most one command for it.
  ifp_front #(
    .MaxWidth(MaxWidth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // Decouple parsing from emission so each side stalls on its own.
  ifp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  // Convert and emit characters through a registered output beat.
  ifp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: bench/ifp_print_checker.sv
// Scoreboard for the integer format-string printer: watches both channels,
// predicts the printed characters per accepted format byte and compares them.
// Depends on ifp_pkg for the payload structs and the character codes.
module ifp_print_checker #(
  parameter int unsigned MaxWidth = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  ifp_pkg::ifp_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  ifp_pkg::ifp_out_t out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       beats_seen_o,
  output int unsigned       chars_checked_o,
  output int unsigned       conversions_o,
  output int unsigned       hex_conversions_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ChLowerA = 8'h61;

  // Spec parser state of the predictor.
  bit         spec_open;
  bit         want_prefix;
  bit         zero_pad;
  bit         long_arg;
  bit         reading_width;
  logic [5:0] field_width;

  ifp_pkg::ifp_out_t expected_chars [$];
  ifp_pkg::ifp_out_t oldest;
  int unsigned       fails;
  int unsigned       beats_seen;
  int unsigned       chars_checked;
  int unsigned       conversions;
  int unsigned       hex_conversions;

  function automatic void clear_spec();
    spec_open     = 1'b0;
    want_prefix   = 1'b0;
    zero_pad      = 1'b0;
    long_arg      = 1'b0;
    reading_width = 1'b0;
    field_width   = '0;
  endfunction

  function automatic void queue_char(logic [7:0] ch);
    ifp_pkg::ifp_out_t item;
    item.out_char = ch;
    item.run_end  = 1'b0;
    expected_chars.push_back(item);
  endfunction

  // Prefix, then zero padding, then the digits of the (possibly truncated) value.
  function automatic void render_number(logic [63:0] value, bit as_hex);
    logic [7:0]  digits [$];
    logic [63:0] v;
    logic [3:0]  nib;
    bit          leading;
    int          pad;
    v = long_arg ? value : {32'h0, value[31:0]};
    if (as_hex) begin
      leading = 1'b1;
      for (int i = 15; i >= 0; i--) begin
        nib = v[i*4 +: 4];
        if (!(leading && nib == 4'h0)) begin
          leading = 1'b0;
          digits.push_back(nib < 4'd10 ? ifp_pkg::ChZero + 8'(nib)
                                       : ChLowerA + 8'(nib) - 8'd10);
        end
      end
      if (digits.size() == 0) digits.push_back(ifp_pkg::ChZero);
      hex_conversions++;
    end else begin
      do begin
        digits.push_front(ifp_pkg::ChZero + 8'(v % 64'd10));
        v = v / 64'd10;
      end while (v != 0);
    end
    if (want_prefix) begin
      queue_char(ifp_pkg::ChZero);
      queue_char(ifp_pkg::ChHex);
    end
    if (zero_pad) begin
      pad = int'(field_width) - int'(digits.size());
      for (int i = 0; i < pad; i++) queue_char(ifp_pkg::ChZero);
    end
    foreach (digits[i]) queue_char(digits[i]);
    conversions++;
  endfunction

  function automatic void predict_beat(ifp_pkg::ifp_in_t beat);
    int unsigned       first;
    int unsigned       w;
    bit                consumed;
    ifp_pkg::ifp_out_t tail;
    first = expected_chars.size();
    if (!spec_open) begin
      if (beat.fmt_byte == ifp_pkg::ChPercent) begin
        clear_spec();
        spec_open = 1'b1;
      end else begin
        queue_char(beat.fmt_byte);
      end
    end else begin
      consumed = 1'b0;
      if (reading_width) begin
        if (beat.fmt_byte >= ifp_pkg::ChZero && beat.fmt_byte <= ifp_pkg::ChNine) begin
          w = field_width * 10 + (beat.fmt_byte - ifp_pkg::ChZero);
          if (w > MaxWidth) w = MaxWidth;
          field_width = w[5:0];
          consumed = 1'b1;
        end else begin
          reading_width = 1'b0;
        end
      end
      if (!consumed) begin
        case (beat.fmt_byte)
          ifp_pkg::ChHash: want_prefix = 1'b1;
          ifp_pkg::ChLong: long_arg = 1'b1;
          ifp_pkg::ChZero: begin
            zero_pad      = 1'b1;
            reading_width = 1'b1;
            field_width   = '0;
          end
          ifp_pkg::ChMinus, ifp_pkg::ChSpace, ifp_pkg::ChPlus: ;
          ifp_pkg::ChHex: begin
            render_number(beat.arg_value, 1'b1);
            clear_spec();
          end
          default: begin
            render_number(beat.arg_value, 1'b0);
            clear_spec();
          end
        endcase
      end
    end
    if (beat.is_last) begin
      if (spec_open) render_number(beat.arg_value, 1'b0);
      clear_spec();
    end
    if (expected_chars.size() > first) begin
      tail = expected_chars.pop_back();
      tail.run_end = 1'b1;
      expected_chars.push_back(tail);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_chars.delete();
      clear_spec();
      fails           = 0;
      beats_seen      = 0;
      chars_checked   = 0;
      conversions     = 0;
      hex_conversions = 0;
    end else begin
      // Check outputs first: a beat accepted at this edge cannot stem from this edge's input.
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          fails++;
          $display("%0t: unexpected character, expected nothing, got %h run_end %b",
                   $time, out_data_i.out_char, out_data_i.run_end);
        end else begin
          oldest = expected_chars.pop_front();
          chars_checked++;
          if (out_data_i.out_char !== oldest.out_char) begin
            fails++;
            $display("%0t: out_char mismatch, expected %h, got %h",
                     $time, oldest.out_char, out_data_i.out_char);
          end
          if (out_data_i.run_end !== oldest.run_end) begin
            fails++;
            $display("%0t: run_end mismatch, expected %b, got %b",
                     $time, oldest.run_end, out_data_i.run_end);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        beats_seen++;
        predict_beat(in_data_i);
      end
    end
    fail_count_o      <= fails;
    pending_o         <= expected_chars.size();
    beats_seen_o      <= beats_seen;
    chars_checked_o   <= chars_checked;
    conversions_o     <= conversions;
    hex_conversions_o <= hex_conversions;
  end

endmodule

FILE: bench/testbench.sv
// Top of the bench for the integer format-string printer: clock, reset, stimulus,
// output back-pressure and the verdict. Depends on ifp_pkg, the printer RTL and
// ifp_print_checker, which does all prediction and comparison.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxWidth    = 32;
  localparam int unsigned RandomBytes = 50;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned TailCycles  = 80;
  localparam int unsigned CycleLimit  = 400000;

  // Conversion byte for decimal; the package has no name for it.
  localparam logic [7:0] ChDec = 8'h69;

  localparam logic [7:0] FlagBytes [5] = '{
    ifp_pkg::ChHash, ifp_pkg::ChLong, ifp_pkg::ChMinus, ifp_pkg::ChSpace, ifp_pkg::ChPlus
  };
  localparam logic [7:0] NoiseBytes [10] = '{
    ifp_pkg::ChPercent, ifp_pkg::ChHash, ifp_pkg::ChLong, ifp_pkg::ChZero, ifp_pkg::ChNine,
    ifp_pkg::ChMinus, ifp_pkg::ChSpace, ifp_pkg::ChPlus, ifp_pkg::ChHex, ChDec
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ifp_pkg::ifp_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ifp_pkg::ifp_out_t out_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_seen;
  int unsigned chars_checked;
  int unsigned conversions;
  int unsigned hex_conversions;

  // Idle bounds per side, varied by the stimulus; zero gives stretches with no idling.
  int unsigned in_gap_max = 9;
  int unsigned out_gap_max = 9;
  // The stimulus bumps this to ask the receiver for one long hold-off.
  int unsigned hold_requests = 0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_format_string_printer_top #(
    .MaxWidth(MaxWidth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  ifp_print_checker #(
    .MaxWidth(MaxWidth)
  ) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .beats_seen_o     (beats_seen),
    .chars_checked_o  (chars_checked),
    .conversions_o    (conversions),
    .hex_conversions_o(hex_conversions)
  );

  // Mix of corner values and fully random 64-bit arguments.
  function automatic logic [63:0] pick_arg();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return {32'h0, 32'($urandom)};
      3: return 64'($urandom_range(0, 99));
      4: return 64'd1 << $urandom_range(0, 63);
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Offer one beat after a random gap and hold it until accepted. Drop valid only
  // when a gap follows, so valid is never lowered and raised in the same step.
  task automatic send_beat(input logic [7:0] ch, input logic [63:0] arg, input logic last);
    int unsigned      gap;
    ifp_pkg::ifp_in_t beat;
    gap = $urandom_range(0, in_gap_max);
    beat.fmt_byte  = ch;
    beat.arg_value = arg;
    beat.is_last   = last;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  // Send a whole format fragment with one argument; mark its final byte as last if asked.
  task automatic send_text(input string text, input logic [63:0] arg, input bit close_run);
    for (int i = 0; i < text.len(); i++) begin
      send_beat(text[i], arg, close_run && (i == text.len() - 1));
    end
  endtask

  // Hold the sender until every predicted character has arrived, then let the block settle.
  task automatic pause_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TailCycles) @(posedge clk);
  endtask

  // Receiver: draw a stall length per beat, or serve a long hold-off when one is asked for.
  initial begin : receiver
    int unsigned hold;
    int unsigned holds_served;
    holds_served = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        hold = LongHold;
        holds_served++;
      end else begin
        hold = $urandom_range(0, out_gap_max);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  text_q [$];
    int unsigned random_sent;
    bit          drained;
    random_sent = 0;
    drained     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: echo of the byte extremes.
    send_beat(8'h00, '1, 1'b0);
    send_beat(8'hff, 64'd0, 1'b0);
    // Hex zero prints a single digit.
    send_text("%x", 64'd0, 1'b0);
    // Largest 64-bit hex value.
    send_text("%lx", '1, 1'b0);
    // Prefix, saturated width and the largest decimal value: the longest run.
    send_text("%#040li", '1, 1'b0);
    // Ignored flags; without 'l' the upper half is dropped.
    send_text("%-+i", 64'hdead_beef_ffff_ffff, 1'b0);
    // A digit outside a width run closes the spec as decimal.
    send_text("%9", 64'd7, 1'b0);
    // A second '%' closes as decimal too.
    send_text("%%", 64'd0, 1'b0);
    // A later '0' restarts the width: ends up as seven.
    send_text("%03 07x", 64'h0000_0000_00ab_cdef, 1'b0);
    // Spec still open on the last byte, with and without a zero flag.
    send_text("%0", 64'd42, 1'b1);
    send_text("%", 64'd99, 1'b1);

    // Pressure: ask for a long receiver hold-off and keep offering long conversions.
    hold_requests++;
    in_gap_max = 0;
    repeat (4) send_text("%#040li", pick_arg(), 1'b0);
    in_gap_max = 9;

    // Random part: mostly well-formed specs with random content, some noise.
    while (random_sent < RandomBytes) begin
      if (!drained && random_sent >= RandomBytes / 2) begin
        pause_for_drain();
        drained = 1'b1;
      end
      in_gap_max  = ($urandom_range(0, 5) == 0) ? 0 : 9;
      out_gap_max = ($urandom_range(0, 5) == 0) ? 0 : 9;
      text_q.delete();
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0, 1: text_q.push_back(8'($urandom_range(0, 255)));
          2: repeat ($urandom_range(1, 4)) text_q.push_back(NoiseBytes[$urandom_range(0, 9)]);
          default: begin
            text_q.push_back(ifp_pkg::ChPercent);
            repeat ($urandom_range(0, 3)) text_q.push_back(FlagBytes[$urandom_range(0, 4)]);
            if ($urandom_range(0, 1) != 0) begin
              text_q.push_back(ifp_pkg::ChZero);
              repeat ($urandom_range(0, 2))
                text_q.push_back(ifp_pkg::ChZero + 8'($urandom_range(0, 9)));
            end
            case ($urandom_range(0, 9))
              0, 1, 2, 3: text_q.push_back(ifp_pkg::ChHex);
              4, 5, 6: text_q.push_back(ChDec);
              7: text_q.push_back(8'($urandom_range(0, 255)));
              default: ; // leave the spec open
            endcase
          end
        endcase
      end
      foreach (text_q[i]) begin
        send_beat(text_q[i], pick_arg(), i == text_q.size() - 1);
        random_sent++;
      end
    end

    // Drain and let any late character show up before the verdict.
    in_gap_max = 0;
    pause_for_drain();
    $display("covered: %0d format bytes, %0d characters checked, %0d conversions (%0d hex)",
             beats_seen, chars_checked, conversions, hex_conversions);
    $display("covered: one long receiver hold-off and one full drain pause in mid-run");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d characters still expected", fail_count, pending);
      $display("status: fail");
    end
    $finish;
  end

endmodule
